// ===== hdl/rgbm_pkg.sv =====
// rgbm_pkg: word types and constants for the background mask block.
// No dependencies; imported by the top level of the block and by its testbench.
`default_nettype none
package rgbm_pkg;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  chan_b;
        logic [7:0]  chan_g;
        logic [7:0]  chan_r;
        logic        end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  mask_value;
        logic [15:0] out_index;
        logic        out_last;
    } out_word_t;

    // register map, indexed by paddr[2]
    localparam logic REG_ALPHA  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    localparam logic [16:0] ALPHA_RESET  = 17'd1311;
    localparam logic [16:0] ALPHA_ONE    = 17'd65536;
    localparam logic [7:0]  THRESH_RESET = 8'd0;
    localparam logic [7:0]  MASK_ON      = 8'd255;
    localparam logic [7:0]  MASK_OFF     = 8'd0;

endpackage
`default_nettype wire

// ===== hdl/rgbm_ram.sv =====
// rgbm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module rgbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/running_gaussian_background_mask.sv =====
// Running Gaussian background mask: top level, per-pixel state in two RAMs.
// Depends on rgbm_pkg and rgbm_ram.
//
// Usage:
//   s_ channel takes one pixel word (index, b/g/r samples, end of frame).
//   m_ channel gives one mask word per pixel once the first frame is done;
//   first-frame pixels only load the mean/variance RAMs.
//   APB port: alpha_q16 at 0x0, mask_threshold at 0x4; write only when idle.
// Timing:
//   A mask word passes 5 read/blend stages (RAM read, blend multiply, new
//   mean and distance, square, variance multiply), a divider load stage, 40
//   one-bit divider stages, one sum stage, 8 square-root stages, then the
//   output register; the first stage loads at the accepting edge.
//   One pixel per cycle sustained, except in an output stall or when a pixel
//   index matches one of the previous five words: that pixel is held off until
//   the word has written back (read-modify-write window of the RAMs).
// Reset:
//   Clears the pipeline, the primed flag and the registers; RAM contents are
//   undefined and are loaded by the first frame.
// Stall:
//   When m_ready is low with a word waiting, the whole pipeline holds and
//   s_ready drops; no word is lost.
`default_nettype none
module running_gaussian_background_mask #(
    parameter int NUM_PIXELS = 65536
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rgbm_pkg::in_word_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rgbm_pkg::out_word_t       m_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);
    import rgbm_pkg::*;

    localparam int AW      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int NDIV    = 40;
    localparam int NROOT   = 8;
    localparam int ST_DIV  = 6;
    localparam int ST_SUM  = ST_DIV + NDIV + 1;
    localparam int NST     = ST_SUM + NROOT;

    typedef struct packed {
        logic [15:0] idx;
        logic        last;
        logic        primed;
        logic        inr;
    } side_t;

    // configuration
    logic [16:0] alpha_reg;
    logic [7:0]  thr_reg;
    logic        primed_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_THRESH) ? {24'd0, thr_reg} : {15'd0, alpha_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            thr_reg   <= THRESH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ALPHA:  alpha_reg <= pwdata[16:0];
                REG_THRESH: thr_reg   <= pwdata[7:0];
                default:    alpha_reg <= alpha_reg;
            endcase
        end
    end

    logic [16:0] a_eff;
    logic [16:0] inv_a;
    assign a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign inv_a = ALPHA_ONE - a_eff;

    // pipeline control
    logic        m_valid_reg;
    out_word_t   m_data_reg;
    logic        adv;
    logic        hazard;
    logic        accept;
    logic        vl_reg [1:NST];
    side_t       sd_reg [1:NST];
    logic [2:0][7:0] fx_reg [1:5];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !hazard;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        hazard = 1'b0;
        for (int i = 1; i <= 5; i++) begin
            if (vl_reg[i] && sd_reg[i].idx == s_data.pixel_index) begin
                hazard = 1'b1;
            end
        end
    end

    // state memories: three channels per row
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [47:0]   mean_wd;
    logic [71:0]   var_wd;
    logic [47:0]   mean_rd;
    logic [71:0]   var_rd;

    rgbm_ram #(.WIDTH(48), .DEPTH(NUM_PIXELS)) u_mean_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (mean_wd),
        .re    (accept),
        .raddr (AW'(s_data.pixel_index)),
        .rdata (mean_rd)
    );

    rgbm_ram #(.WIDTH(72), .DEPTH(NUM_PIXELS)) u_var_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (var_wd),
        .re    (accept),
        .raddr (AW'(s_data.pixel_index)),
        .rdata (var_rd)
    );

    // front stages
    logic [32:0] pm1_reg [3];
    logic [32:0] pm2_reg [3];
    logic [40:0] pv1_reg [2:5][3];
    logic [15:0] m_reg   [3:5][3];
    logic [15:0] ad_reg  [3];
    logic [31:0] sq_reg  [3];
    logic [23:0] d2_reg  [3];
    logic [40:0] pv2_reg [3];

    logic [33:0] msum    [3];
    logic [15:0] m_next  [3];
    logic [15:0] ad_next [3];
    logic [31:0] sqr     [3];
    logic [41:0] vsum    [3];
    logic [23:0] v_next  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            msum[c]    = 34'(pm1_reg[c]) + 34'(pm2_reg[c]) + 34'd32768;
            m_next[c]  = msum[c][31:16];
            ad_next[c] = ({fx_reg[2][c], 8'd0} >= m_next[c]) ?
                         {fx_reg[2][c], 8'd0} - m_next[c] :
                         m_next[c] - {fx_reg[2][c], 8'd0};
            sqr[c]     = sq_reg[c] + 32'd128;
            vsum[c]    = 42'(pv1_reg[5][c]) + 42'(pv2_reg[c]) + 42'd32768;
            v_next[c]  = vsum[c][39:16];
        end
    end

    // write-back from stage 5
    assign wr_en   = adv && vl_reg[5] && sd_reg[5].inr;
    assign wr_addr = AW'(sd_reg[5].idx);
    assign mean_wd = sd_reg[5].primed ? {m_reg[5][2], m_reg[5][1], m_reg[5][0]} :
                     {fx_reg[5][2], 8'd0, fx_reg[5][1], 8'd0, fx_reg[5][0], 8'd0};
    assign var_wd  = sd_reg[5].primed ? {v_next[2], v_next[1], v_next[0]} : 72'd0;

    // valid / side shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NST; i++) begin
                vl_reg[i] <= 1'b0;
            end
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && s_data.end_of_frame) begin
                primed_reg <= 1'b1;
            end
            if (adv) begin
                vl_reg[1] <= accept;
                for (int i = 2; i <= NST; i++) begin
                    vl_reg[i] <= vl_reg[i-1];
                end
                m_valid_reg <= vl_reg[NST] && sd_reg[NST].primed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[1].idx    <= s_data.pixel_index;
            sd_reg[1].last   <= s_data.end_of_frame;
            sd_reg[1].primed <= primed_reg;
            sd_reg[1].inr    <= 32'(s_data.pixel_index) < 32'(NUM_PIXELS);
            for (int i = 2; i <= NST; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
            fx_reg[1] <= {s_data.chan_r, s_data.chan_g, s_data.chan_b};
            for (int i = 2; i <= 5; i++) begin
                fx_reg[i] <= fx_reg[i-1];
            end
            for (int c = 0; c < 3; c++) begin
                // stage 2: blend products
                pm1_reg[c]    <= 33'(inv_a) * 33'(mean_rd[16*c +: 16]);
                pm2_reg[c]    <= 33'(a_eff) * 33'({fx_reg[1][c], 8'd0});
                pv1_reg[2][c] <= 41'(inv_a) * 41'(var_rd[24*c +: 24]);
                // stage 3: new mean, distance
                m_reg[3][c]   <= m_next[c];
                ad_reg[c]     <= ad_next[c];
                pv1_reg[3][c] <= pv1_reg[2][c];
                // stage 4: square
                sq_reg[c]     <= 32'(ad_reg[c]) * 32'(ad_reg[c]);
                m_reg[4][c]   <= m_reg[3][c];
                pv1_reg[4][c] <= pv1_reg[3][c];
                // stage 5: d2 and its weight
                d2_reg[c]     <= sqr[c][31:8];
                pv2_reg[c]    <= 41'(a_eff) * 41'(sqr[c][31:8]);
                m_reg[5][c]   <= m_reg[4][c];
                pv1_reg[5][c] <= pv1_reg[4][c];
            end
        end
    end

    // divider: d2*65536 / var, one quotient bit per stage
    logic [23:0] dv_rem_reg [0:NDIV][3];
    logic [39:0] dv_nq_reg  [0:NDIV][3];
    logic [23:0] dv_div_reg [0:NDIV][3];
    logic        dv_z_reg   [0:NDIV][3];
    logic [23:0] dv_rem_next [1:NDIV][3];
    logic [39:0] dv_nq_next  [1:NDIV][3];

    always_comb begin
        logic [24:0] t;
        for (int k = 1; k <= NDIV; k++) begin
            for (int c = 0; c < 3; c++) begin
                t = {dv_rem_reg[k-1][c], dv_nq_reg[k-1][c][39]};
                if (t >= {1'b0, dv_div_reg[k-1][c]}) begin
                    dv_rem_next[k][c] = 24'(t - {1'b0, dv_div_reg[k-1][c]});
                    dv_nq_next[k][c]  = {dv_nq_reg[k-1][c][38:0], 1'b1};
                end else begin
                    dv_rem_next[k][c] = t[23:0];
                    dv_nq_next[k][c]  = {dv_nq_reg[k-1][c][38:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                dv_rem_reg[0][c] <= 24'd0;
                dv_nq_reg[0][c]  <= {d2_reg[c], 16'd0};
                dv_div_reg[0][c] <= v_next[c];
                dv_z_reg[0][c]   <= (v_next[c] == 24'd0);
                for (int k = 1; k <= NDIV; k++) begin
                    dv_rem_reg[k][c] <= dv_rem_next[k][c];
                    dv_nq_reg[k][c]  <= dv_nq_next[k][c];
                    dv_div_reg[k][c] <= dv_div_reg[k-1][c];
                    dv_z_reg[k][c]   <= dv_z_reg[k-1][c];
                end
            end
        end
    end

    // sum and rounded square root, one result bit per stage
    logic [39:0] q_final   [3];
    logic [41:0] sq_s_reg  [0:NROOT];
    logic [7:0]  sq_n_reg  [1:NROOT];
    logic [7:0]  sq_n_next [1:NROOT];

    always_comb begin
        logic [7:0]  n_prev;
        logic [7:0]  cand;
        logic [8:0]  t9;
        logic [17:0] tt;
        for (int c = 0; c < 3; c++) begin
            q_final[c] = dv_z_reg[NDIV][c] ? 40'd0 : dv_nq_reg[NDIV][c];
        end
        for (int j = 1; j <= NROOT; j++) begin
            n_prev = (j == 1) ? 8'd0 : sq_n_reg[(j == 1) ? 1 : j-1];
            cand   = n_prev | (8'd128 >> (j-1));
            t9     = {cand, 1'b0} - 9'd1;
            tt     = 18'(t9) * 18'(t9);
            sq_n_next[j] = ({10'd0, tt, 14'd0} <= sq_s_reg[j-1]) ? cand : n_prev;
        end
    end

    logic [7:0] root_val;
    logic [7:0] mask_next;
    assign root_val = sq_n_reg[NROOT];

    always_comb begin
        if (!sd_reg[NST].inr) begin
            mask_next = MASK_OFF;
        end else if (thr_reg != 8'd0) begin
            mask_next = (root_val > thr_reg) ? MASK_ON : MASK_OFF;
        end else begin
            mask_next = root_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_s_reg[0] <= 42'(q_final[0]) + 42'(q_final[1]) + 42'(q_final[2]);
            for (int j = 1; j <= NROOT; j++) begin
                sq_s_reg[j] <= sq_s_reg[j-1];
                sq_n_reg[j] <= sq_n_next[j];
            end
            m_data_reg.mask_value <= mask_next;
            m_data_reg.out_index  <= sd_reg[NST].idx;
            m_data_reg.out_last   <= sd_reg[NST].last;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for running_gaussian_background_mask.
// Depends on rgbm_pkg and the block's RTL; predicts mask words with its own model.
`timescale 1ns / 1ps
module tb_top;
    import rgbm_pkg::*;

    localparam int NPIX = 16;          // small pixel set exercised
    localparam int DRAIN = 80;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    running_gaussian_background_mask u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial forever #1 aclk = ~aclk;

    // predictor state
    logic [15:0] mean_q[65536][3];
    logic [23:0] var_q[65536][3];
    logic        primed;
    logic [16:0] alpha;
    logic [7:0]  thresh;

    in_word_t  pixel_q[$];
    out_word_t mask_q[$];
    int  errors = 0;
    bit  stim_done = 0;
    int  hold_off = 0;          // long receiver stall request

    function automatic logic [63:0] blend(logic [63:0] old, logic [63:0] nw, logic [63:0] a);
        return ((64'd65536 - a) * old + a * nw + 64'd32768) >> 16;
    endfunction

    function automatic logic [7:0] round_root(logic [63:0] s);
        logic [8:0] n;
        logic [63:0] t;
        n = 0;
        for (int b = 128; b != 0; b >>= 1) begin
            t = 2 * (n | b) - 1;
            if (t * t * 16384 <= s)
                n = n | b;
        end
        return n[7:0];
    endfunction

    task automatic predict_mask(input in_word_t w);
        logic [63:0] a, x8, m, ad, d2, v, sum;
        logic [7:0] xs[3];
        logic [7:0] val;
        out_word_t o;
        a = alpha > ALPHA_ONE ? 64'd65536 : 64'(alpha);
        xs[0] = w.chan_b; xs[1] = w.chan_g; xs[2] = w.chan_r;
        sum = 0;
        if (!primed) begin
            for (int c = 0; c < 3; c++) begin
                mean_q[w.pixel_index][c] = {xs[c], 8'd0};
                var_q[w.pixel_index][c] = '0;
            end
            if (w.end_of_frame)
                primed = 1'b1;
            return;
        end
        for (int c = 0; c < 3; c++) begin
            x8 = 64'(xs[c]) << 8;
            m = blend(64'(mean_q[w.pixel_index][c]), x8, a);
            ad = x8 >= m ? x8 - m : m - x8;
            d2 = (ad * ad + 128) >> 8;
            v = blend(64'(var_q[w.pixel_index][c]), d2, a) & 64'hFFFFFF;
            mean_q[w.pixel_index][c] = m[15:0];
            var_q[w.pixel_index][c] = v[23:0];
            if (v != 0)
                sum += (d2 << 16) / v;
        end
        val = round_root(sum);
        if (thresh > 0)
            val = val > thresh ? MASK_ON : MASK_OFF;
        o.mask_value = val;
        o.out_index = w.pixel_index;
        o.out_last = w.end_of_frame;
        mask_q.push_back(o);
    endtask

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_mask(s_data);
                void'(pixel_q.pop_front());
                s_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
                if (pixel_q.size() > 0 && $urandom_range(0, 3) != 0) begin
                    s_data <= pixel_q[0];
                    s_valid <= 1'b1;
                end else
                    s_valid <= 1'b0;
            end else if (!s_valid) begin
                if (s_gap > 0)
                    s_gap <= s_gap - 1;
                else if (pixel_q.size() > 0) begin
                    s_data <= pixel_q[0];
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (mask_q.size() == 0) begin
                    $error("unexpected mask word %h", m_data);
                    errors++;
                end else begin
                    if (m_data.mask_value !== mask_q[0].mask_value) begin
                        $error("mask_value exp %0d got %0d", mask_q[0].mask_value,
                               m_data.mask_value);
                        errors++;
                    end
                    if (m_data.out_index !== mask_q[0].out_index) begin
                        $error("out_index exp %0d got %0d", mask_q[0].out_index,
                               m_data.out_index);
                        errors++;
                    end
                    if (m_data.out_last !== mask_q[0].out_last) begin
                        $error("out_last exp %0d got %0d", mask_q[0].out_last,
                               m_data.out_last);
                        errors++;
                    end
                    void'(mask_q.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready && $urandom_range(0, 3) == 0)
                    m_gap <= $urandom_range(0, 11);
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0)
            alpha = data[16:0];
        else
            thresh = data[7:0];
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_valid || mask_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic in_word_t make_pixel(int idx, bit eof);
        in_word_t w;
        w.pixel_index = 16'(idx);
        w.chan_b = $urandom; w.chan_g = $urandom; w.chan_r = $urandom;
        w.end_of_frame = eof;
        return w;
    endfunction

    // send one frame over pixels 0..NPIX-1, optionally with the far pixel mixed in
    task automatic queue_frame(bit with_stray);
        for (int i = 0; i < NPIX; i++)
            pixel_q.push_back(make_pixel(i, i == NPIX - 1));
        if (with_stray)
            pixel_q.insert($urandom_range(0, NPIX - 1), make_pixel(65535, 0));
    endtask

    initial begin
        in_word_t w;
        primed = 0; alpha = ALPHA_RESET; thresh = THRESH_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // first frame with extremes, plus the top index so later frames may use it
        w = make_pixel(0, 0); w.chan_b = 0; w.chan_g = 0; w.chan_r = 0;
        pixel_q.push_back(w);
        w = make_pixel(1, 0); w.chan_b = 8'hFF; w.chan_g = 8'hFF; w.chan_r = 8'hFF;
        pixel_q.push_back(w);
        pixel_q.push_back(make_pixel(65535, 0));
        for (int i = 2; i < NPIX; i++)
            pixel_q.push_back(make_pixel(i, i == NPIX - 1));
        // second frame, extremes opposite, same index back to back, stray index
        w = make_pixel(0, 0); w.chan_b = 8'hFF; w.chan_g = 8'hFF; w.chan_r = 8'hFF;
        pixel_q.push_back(w);
        w = make_pixel(1, 0); w.chan_b = 0; w.chan_g = 0; w.chan_r = 0;
        pixel_q.push_back(w);
        pixel_q.push_back(make_pixel(1, 0));
        pixel_q.push_back(make_pixel(65535, 1));
        wait_idle();

        // sweep settings, extremes included; sender pauses until idle between phases
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin apb_write(3'd0, 32'd0);      apb_write(3'd4, 32'd0);   end
                1: begin apb_write(3'd0, 32'd65536);  apb_write(3'd4, 32'd255); end
                2: begin apb_write(3'd0, 32'h1FFFF);  apb_write(3'd4, 32'd1);   end
                3: begin apb_write(3'd0, 32'd1);      apb_write(3'd4, 32'd0);   end
                default: begin
                    apb_write(3'd0, $urandom_range(0, 2) == 0 ? $urandom_range(0, 131071)
                                                              : $urandom_range(200, 20000));
                    apb_write(3'd4, $urandom_range(0, 1) ? 0 : $urandom_range(1, 255));
                end
            endcase
            if (ph == 4)
                hold_off = 300;     // receiver stalls long while pixels keep coming
            for (int f = 0; f < 4; f++)
                queue_frame($urandom_range(0, 4) == 0);
            wait_idle();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/rgbm_pkg.sv
hdl/rgbm_ram.sv
hdl/running_gaussian_background_mask.sv
tb/sv/tb_top.sv
